FILE: rtl/modbus_request_validator_top_defines.svh
// Assertion macros for the Modbus request validator.
// Expects clk and rst_n in the scope of each use.
`ifndef MODBUS_REQUEST_VALIDATOR_TOP_DEFINES_SVH
`define MODBUS_REQUEST_VALIDATOR_TOP_DEFINES_SVH

// Antecedent implies consequent at the same edge
`define MRV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("validator check failed");

// Antecedent implies consequent a fixed number of cycles later
`define MRV_ASSERT_LAT(lbl, ante, cons, n) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("validator latency check failed");

`endif

FILE: rtl/mrv_pkg.sv
// Types, codes and limits shared by the Modbus request validator.
// No dependencies.
`default_nettype none

package mrv_pkg;

    // Unit id and function code
    localparam logic [7:0]  ID_MAX       = 8'd247;
    localparam logic [7:0]  ID_BROADCAST = 8'd0;
    localparam int          FC_EXC_BIT   = 7;

    localparam logic [7:0]  FC_READ_COILS     = 8'd1;
    localparam logic [7:0]  FC_READ_DISCRETE  = 8'd2;
    localparam logic [7:0]  FC_READ_HOLDING   = 8'd3;
    localparam logic [7:0]  FC_READ_INPUT     = 8'd4;
    localparam logic [7:0]  FC_WRITE_COIL     = 8'd5;
    localparam logic [7:0]  FC_WRITE_REG      = 8'd6;
    localparam logic [7:0]  FC_WRITE_COILS    = 8'd15;
    localparam logic [7:0]  FC_WRITE_REGS     = 8'd16;

    // Count limits per function code
    localparam logic [15:0] LIMIT_READ_BITS   = 16'd2000;
    localparam logic [15:0] LIMIT_WRITE_BITS  = 16'd1968;
    localparam logic [15:0] LIMIT_READ_REGS   = 16'd125;
    localparam logic [15:0] LIMIT_WRITE_REGS  = 16'd123;

    localparam logic [16:0] ADDR_SPACE  = 17'h10000;
    localparam logic [15:0] REG_BYTES   = 16'd2;
    localparam logic [7:0]  COIL_ON_HI  = 8'hFF;
    localparam logic [7:0]  COIL_OFF_HI = 8'h00;
    localparam logic [7:0]  COIL_LO     = 8'h00;

    typedef enum logic [2:0] {
        CLS_BITS,
        CLS_REGS,
        CLS_COIL,
        CLS_REG1,
        CLS_BAD
    } fc_class_t;

    // One request descriptor
    typedef struct packed {
        logic [7:0]  unit_id;
        logic [7:0]  function_code;
        logic [7:0]  exception_code;
        logic [15:0] start_address;
        logic [15:0] item_count;
        logic        buffer_present;
        logic [15:0] buffer_bytes;
        logic [7:0]  value_high_byte;
        logic [7:0]  value_low_byte;
    } item_t;

    // Partial checks handed from decode to the verdict stage
    typedef struct packed {
        logic        id_bad;
        logic        exc_bit;
        logic        exc_present;
        logic        broadcast;
        fc_class_t   cls;
        logic        count_ok;
        logic        addr_ok;
        logic        present;
        logic [16:0] need;
        logic [15:0] have;
        logic        have_two;
        logic        coil_ok;
    } flags_t;

endpackage

`default_nettype wire

FILE: rtl/modbus_request_validator_top.sv
// Modbus request validator: one verdict per request descriptor.
// The done strobe follows the start transfer through the stages below; one request per cycle,
// busy never rises. Stages: input register, decode register, verdict register.
// Reset clears the stage valid bits; payload registers are not reset.
// Depends on mrv_pkg, mrv_decode and modbus_request_validator_top_defines.svh.
`default_nettype none
`include "modbus_request_validator_top_defines.svh"

module modbus_request_validator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  unit_id,
    input  wire logic [7:0]  function_code,
    input  wire logic [7:0]  exception_code,
    input  wire logic [15:0] start_address,
    input  wire logic [15:0] item_count,
    input  wire logic        buffer_present,
    input  wire logic [15:0] buffer_bytes,
    input  wire logic [7:0]  value_high_byte,
    input  wire logic [7:0]  value_low_byte,
    output logic             done,
    output logic             verdict
);
    import mrv_pkg::*;

    item_t  item_next;
    item_t  item_reg;
    logic   s1_valid_reg;
    flags_t flags_next;
    flags_t flags_reg;
    logic   s2_valid_reg;
    logic   verdict_next;
    logic   verdict_reg;
    logic   done_reg;
    logic   need_met;
    logic   hard_reject_in;

    // Every cycle takes a transfer
    assign busy = 1'b0;

    assign item_next = '{
        unit_id:         unit_id,
        function_code:   function_code,
        exception_code:  exception_code,
        start_address:   start_address,
        item_count:      item_count,
        buffer_present:  buffer_present,
        buffer_bytes:    buffer_bytes,
        value_high_byte: value_high_byte,
        value_low_byte:  value_low_byte
    };

    // Advance valid bits down the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    // Hold payload per stage
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        flags_reg   <= flags_next;
        verdict_reg <= verdict_next;
    end

    mrv_decode u_decode (
        .item  (item_reg),
        .flags (flags_next)
    );

    // Compare buffer size against need, then combine in check order
    assign need_met = {1'b0, flags_reg.have} >= flags_reg.need;

    always_comb
    begin
        if (flags_reg.id_bad || flags_reg.exc_bit)
        begin
            verdict_next = 1'b1;
        end
        else if (flags_reg.exc_present)
        begin
            verdict_next = flags_reg.broadcast;
        end
        else
        begin
            case (flags_reg.cls)
                CLS_BITS, CLS_REGS:
                    verdict_next = !(flags_reg.count_ok && flags_reg.addr_ok
                                     && flags_reg.present && need_met);
                CLS_COIL:
                    verdict_next = !(flags_reg.present && flags_reg.have_two
                                     && flags_reg.coil_ok);
                CLS_REG1:
                    verdict_next = !(flags_reg.present && flags_reg.have_two);
                default:
                    verdict_next = 1'b1;
            endcase
        end
    end

    assign done    = done_reg;
    assign verdict = verdict_reg;

    // Flag a request that must end invalid whatever else it carries
    assign hard_reject_in = (unit_id > ID_MAX) || function_code[FC_EXC_BIT];

    // Every accepted request yields a strobe once it has passed the stage registers, and no other
    `MRV_ASSERT_LAT(a_latency, start, done, 3)
    `MRV_ASSERT_IMP(a_no_spurious, done, $past(start, 3))
    // A bad unit id or an exception bit always ends invalid
    `MRV_ASSERT_IMP(a_hard_reject, done && $past(start, 3) && $past(hard_reject_in, 3), verdict)

endmodule

`default_nettype wire

FILE: rtl/mrv_decode.sv
// Decode of one request descriptor into partial check flags.
// Depends on mrv_pkg.
`default_nettype none

module mrv_decode (
    input  mrv_pkg::item_t  item,
    output mrv_pkg::flags_t flags
);
    import mrv_pkg::*;

    fc_class_t   cls;
    logic [15:0] limit;
    logic [16:0] addr_end;
    logic [16:0] need_bits;
    logic [16:0] need_regs;

    // Classify the function code and pick its count limit
    always_comb
    begin
        cls   = CLS_BAD;
        limit = '0;
        case (item.function_code)
            FC_READ_COILS, FC_READ_DISCRETE:
            begin
                cls   = CLS_BITS;
                limit = LIMIT_READ_BITS;
            end
            FC_WRITE_COILS:
            begin
                cls   = CLS_BITS;
                limit = LIMIT_WRITE_BITS;
            end
            FC_READ_HOLDING, FC_READ_INPUT:
            begin
                cls   = CLS_REGS;
                limit = LIMIT_READ_REGS;
            end
            FC_WRITE_REGS:
            begin
                cls   = CLS_REGS;
                limit = LIMIT_WRITE_REGS;
            end
            FC_WRITE_COIL:
            begin
                cls = CLS_COIL;
            end
            FC_WRITE_REG:
            begin
                cls = CLS_REG1;
            end
            default:
            begin
                cls   = CLS_BAD;
                limit = '0;
            end
        endcase
    end

    // Address end and required buffer size
    assign addr_end  = {1'b0, item.start_address} + {1'b0, item.item_count};
    assign need_bits = ({1'b0, item.item_count} + 17'd7) >> 3;
    assign need_regs = {item.item_count, 1'b0};

    always_comb
    begin
        flags.id_bad      = item.unit_id > ID_MAX;
        flags.exc_bit     = item.function_code[FC_EXC_BIT];
        flags.exc_present = item.exception_code != 8'd0;
        flags.broadcast   = item.unit_id == ID_BROADCAST;
        flags.cls         = cls;
        flags.count_ok    = (item.item_count != 16'd0) && (item.item_count <= limit);
        flags.addr_ok     = addr_end <= ADDR_SPACE;
        flags.present     = item.buffer_present;
        flags.need        = (cls == CLS_REGS) ? need_regs : need_bits;
        flags.have        = item.buffer_bytes;
        flags.have_two    = item.buffer_bytes >= REG_BYTES;
        flags.coil_ok     = ((item.value_high_byte == COIL_ON_HI)
                            || (item.value_high_byte == COIL_OFF_HI))
                            && (item.value_low_byte == COIL_LO);
    end

endmodule

`default_nettype wire

FILE: tb/modbus_request_validator_checker.sv
// Scoreboard for the Modbus request validator: predicts one verdict per accepted
// request and compares each done strobe with the oldest prediction.
// Depends on mrv_pkg.
`default_nettype none

module modbus_request_validator_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic           busy,
    input  wire mrv_pkg::item_t request,
    input  wire logic           done,
    input  wire logic           verdict,
    output int                  failures,
    output int                  outstanding
);
    import mrv_pkg::*;

    typedef struct {
        item_t request;
        logic  verdict;
    } verdict_check_t;

    verdict_check_t pending_verdicts [$];
    verdict_check_t oldest;

    // Work out whether a descriptor is rejected (1) or accepted (0)
    function automatic logic rejects(input item_t m);
        logic [16:0] span;
        logic [16:0] bytes_needed;
        logic [15:0] limit;
        logic        word_access;
        span = {1'b0, m.start_address} + {1'b0, m.item_count};
        limit = '0;
        word_access = 1'b0;
        if (m.unit_id > ID_MAX)
            return 1'b1;
        if (m.function_code[FC_EXC_BIT])
            return 1'b1;
        // an exception reply is fine unless it was broadcast
        if (m.exception_code != 8'd0)
            return m.unit_id == ID_BROADCAST;
        case (m.function_code)
            FC_READ_COILS, FC_READ_DISCRETE:
            begin
                limit = LIMIT_READ_BITS;
            end
            FC_WRITE_COILS:
            begin
                limit = LIMIT_WRITE_BITS;
            end
            FC_READ_HOLDING, FC_READ_INPUT:
            begin
                limit = LIMIT_READ_REGS;
                word_access = 1'b1;
            end
            FC_WRITE_REGS:
            begin
                limit = LIMIT_WRITE_REGS;
                word_access = 1'b1;
            end
            FC_WRITE_COIL:
                return !(m.buffer_present && m.buffer_bytes >= REG_BYTES
                         && (m.value_high_byte == COIL_ON_HI
                             || m.value_high_byte == COIL_OFF_HI)
                         && m.value_low_byte == COIL_LO);
            FC_WRITE_REG:
                return !(m.buffer_present && m.buffer_bytes >= REG_BYTES);
            default:
                return 1'b1;
        endcase
        if (m.item_count == 16'd0 || m.item_count > limit)
            return 1'b1;
        if (span > ADDR_SPACE)
            return 1'b1;
        if (!m.buffer_present)
            return 1'b1;
        if (word_access)
            bytes_needed = {1'b0, m.item_count} * {1'b0, REG_BYTES};
        else
            bytes_needed = ({1'b0, m.item_count} + 17'd7) >> 3;
        return {1'b0, m.buffer_bytes} < bytes_needed;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        failures++;
    endtask

    // Retire the oldest prediction on each strobe, then log the new transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_verdicts.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_verdicts.size() == 0)
                    report_mismatch("verdict strobe with no request outstanding");
                else
                begin
                    oldest = pending_verdicts.pop_front();
                    if (verdict !== oldest.verdict)
                        report_mismatch($sformatf("request %p: verdict %b, want %b",
                                                  oldest.request, verdict,
                                                  oldest.verdict));
                end
            end
            if (start && !busy)
                pending_verdicts.push_back('{request, rejects(request)});
            outstanding <= pending_verdicts.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/modbus_request_validator_top_tb.sv
// Testbench top for the Modbus request validator: clock, reset and request stimulus.
// Checking is left to modbus_request_validator_checker; depends on mrv_pkg and the RTL.
`default_nettype none

module modbus_request_validator_top_tb;
    import mrv_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int SETTLE       = 10;
    localparam int CYCLE_LIMIT  = 400000;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    logic  done;
    logic  verdict;
    item_t request;
    int    failures;
    int    outstanding;
    int    cycle_count;

    modbus_request_validator_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .unit_id         (request.unit_id),
        .function_code   (request.function_code),
        .exception_code  (request.exception_code),
        .start_address   (request.start_address),
        .item_count      (request.item_count),
        .buffer_present  (request.buffer_present),
        .buffer_bytes    (request.buffer_bytes),
        .value_high_byte (request.value_high_byte),
        .value_low_byte  (request.value_low_byte),
        .done            (done),
        .verdict         (verdict)
    );

    modbus_request_validator_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .verdict     (verdict),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic item_t descriptor(input logic [7:0] id, input logic [7:0] fc,
                                         input logic [7:0] exc, input logic [15:0] addr,
                                         input logic [15:0] count, input logic present,
                                         input logic [15:0] bytes, input logic [7:0] hi,
                                         input logic [7:0] lo);
        item_t r;
        r = '{id, fc, exc, addr, count, present, bytes, hi, lo};
        return r;
    endfunction

    // Mostly well-formed requests near the limits, the rest plain noise
    function automatic item_t random_request();
        item_t       r;
        int unsigned roll;
        int unsigned limit;
        int unsigned need;
        int unsigned count;
        int unsigned span;
        bit          word_access;
        r.unit_id         = 8'($urandom);
        r.function_code   = 8'($urandom);
        r.exception_code  = 8'($urandom);
        r.start_address   = 16'($urandom);
        r.item_count      = 16'($urandom);
        r.buffer_present  = 1'($urandom);
        r.buffer_bytes    = 16'($urandom);
        r.value_high_byte = 8'($urandom);
        r.value_low_byte  = 8'($urandom);
        if ($urandom_range(0, 99) < 15)
            return r;

        roll = $urandom_range(0, 99);
        if (roll < 4)
            r.unit_id = 8'($urandom_range(248, 255));
        else if (roll < 10)
            r.unit_id = ID_BROADCAST;
        else
            r.unit_id = 8'($urandom_range(1, 247));

        case ($urandom_range(0, 9))
            0: r.function_code = FC_READ_COILS;
            1: r.function_code = FC_READ_DISCRETE;
            2: r.function_code = FC_READ_HOLDING;
            3: r.function_code = FC_READ_INPUT;
            4: r.function_code = FC_WRITE_COIL;
            5: r.function_code = FC_WRITE_REG;
            6: r.function_code = FC_WRITE_COILS;
            7: r.function_code = FC_WRITE_REGS;
            8: r.function_code = 8'($urandom_range(0, 255));
            default: r.function_code = FC_WRITE_COIL;
        endcase

        if ($urandom_range(0, 99) < 88)
            r.exception_code = 8'd0;

        word_access = 1'b0;
        case (r.function_code)
            FC_READ_COILS, FC_READ_DISCRETE: limit = LIMIT_READ_BITS;
            FC_WRITE_COILS:                  limit = LIMIT_WRITE_BITS;
            FC_READ_HOLDING, FC_READ_INPUT:
            begin
                limit = LIMIT_READ_REGS;
                word_access = 1'b1;
            end
            FC_WRITE_REGS:
            begin
                limit = LIMIT_WRITE_REGS;
                word_access = 1'b1;
            end
            default: limit = 4;
        endcase

        // count inside, on and just past its limits
        roll = $urandom_range(0, 99);
        if (roll < 70)
            count = $urandom_range(1, limit);
        else if (roll < 78)
            count = limit;
        else if (roll < 84)
            count = 1;
        else if (roll < 90)
            count = limit + 1;
        else if (roll < 94)
            count = 0;
        else
            count = $urandom_range(0, 65535);
        r.item_count = 16'(count);

        // address clear of, on, or one past the top of the address space
        span = 65536 - count;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            r.start_address = 16'($urandom_range(0, span));
        else if (roll < 80)
            r.start_address = 16'(span);
        else if (roll < 90)
            r.start_address = 16'(span + 1);

        r.buffer_present = ($urandom_range(0, 99) < 92);

        if (r.function_code == FC_WRITE_COIL || r.function_code == FC_WRITE_REG)
            need = 2;
        else if (word_access)
            need = count * 2;
        else
            need = (count + 7) / 8;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            need = need;
        else if (roll < 45 && need > 0)
            need = need - 1;
        else if (roll < 55)
            need = 65535;
        else
            need = need + $urandom_range(0, 40);
        r.buffer_bytes = (need > 65535) ? 16'hFFFF : 16'(need);

        case ($urandom_range(0, 3))
            0: r.value_high_byte = COIL_OFF_HI;
            1: r.value_high_byte = COIL_ON_HI;
            default: r.value_high_byte = 8'($urandom);
        endcase
        if ($urandom_range(0, 99) < 80)
            r.value_low_byte = COIL_LO;
        return r;
    endfunction

    function automatic int unsigned random_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present a request and hold it until the transfer completes
    task automatic send(input item_t r);
        request <= r;
        start   <= 1'b1;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic idle(input int unsigned cycles);
        if (cycles != 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Drop start and hold off until every verdict is back
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        bit quiet;
        clk     = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        quiet   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unit id range
        send(descriptor(8'd248, FC_READ_HOLDING, 8'd0, 16'd0, 16'd1, 1'b1, 16'd2, 8'd0, 8'd0));
        send(descriptor(8'd255, FC_READ_HOLDING, 8'd0, 16'd0, 16'd1, 1'b1, 16'd2, 8'd0, 8'd0));
        send(descriptor(8'd247, FC_READ_HOLDING, 8'd0, 16'd0, 16'd1, 1'b1, 16'd2, 8'd0, 8'd0));
        // exception bit in the function code
        send(descriptor(8'd1, 8'h83, 8'd0, 16'd0, 16'd1, 1'b1, 16'd2, 8'd0, 8'd0));
        send(descriptor(8'd1, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF, 8'hFF));
        // exception code carried: fine unless broadcast
        send(descriptor(8'd5, 8'd99, 8'd1, 16'd0, 16'd0, 1'b0, 16'd0, 8'd0, 8'd0));
        send(descriptor(ID_BROADCAST, FC_READ_COILS, 8'hFF, 16'd0, 16'd1, 1'b1, 16'd1,
                        8'd0, 8'd0));
        // bit access: count limits, address wrap, buffer size
        send(descriptor(8'd1, FC_READ_COILS, 8'd0, 16'd63536, 16'd2000, 1'b1, 16'd250,
                        8'd0, 8'd0));
        send(descriptor(8'd1, FC_READ_DISCRETE, 8'd0, 16'd0, 16'd2001, 1'b1, 16'd300,
                        8'd0, 8'd0));
        send(descriptor(8'd1, FC_READ_COILS, 8'd0, 16'd0, 16'd0, 1'b1, 16'd10, 8'd0, 8'd0));
        send(descriptor(8'd1, FC_WRITE_COILS, 8'd0, 16'd0, 16'd1968, 1'b1, 16'd246,
                        8'd0, 8'd0));
        send(descriptor(8'd1, FC_WRITE_COILS, 8'd0, 16'd0, 16'd1969, 1'b1, 16'd247,
                        8'd0, 8'd0));
        send(descriptor(8'd1, FC_READ_COILS, 8'd0, 16'hFFFF, 16'd1, 1'b1, 16'd1, 8'd0, 8'd0));
        send(descriptor(8'd1, FC_READ_COILS, 8'd0, 16'hFFFF, 16'd2, 1'b1, 16'd1, 8'd0, 8'd0));
        send(descriptor(8'd1, FC_READ_COILS, 8'd0, 16'd0, 16'd9, 1'b1, 16'd1, 8'd0, 8'd0));
        // register access
        send(descriptor(8'd1, FC_READ_HOLDING, 8'd0, 16'd0, 16'd125, 1'b1, 16'd250,
                        8'd0, 8'd0));
        send(descriptor(8'd1, FC_READ_INPUT, 8'd0, 16'd0, 16'd125, 1'b1, 16'd249,
                        8'd0, 8'd0));
        send(descriptor(8'd1, FC_WRITE_REGS, 8'd0, 16'd65413, 16'd123, 1'b1, 16'd246,
                        8'd0, 8'd0));
        send(descriptor(8'd1, FC_WRITE_REGS, 8'd0, 16'd0, 16'd124, 1'b1, 16'd248,
                        8'd0, 8'd0));
        send(descriptor(8'd1, FC_READ_HOLDING, 8'd0, 16'd0, 16'd1, 1'b0, 16'd2, 8'd0, 8'd0));
        // single coil values and short buffer
        send(descriptor(8'd1, FC_WRITE_COIL, 8'd0, 16'd0, 16'd0, 1'b1, 16'd2, 8'hFF, 8'h00));
        send(descriptor(8'd1, FC_WRITE_COIL, 8'd0, 16'd0, 16'd0, 1'b1, 16'd2, 8'h00, 8'h00));
        send(descriptor(8'd1, FC_WRITE_COIL, 8'd0, 16'd0, 16'd0, 1'b1, 16'd2, 8'h01, 8'h00));
        send(descriptor(8'd1, FC_WRITE_COIL, 8'd0, 16'd0, 16'd0, 1'b1, 16'd1, 8'hFF, 8'h00));
        // single register and unknown codes
        send(descriptor(8'd1, FC_WRITE_REG, 8'd0, 16'd0, 16'd0, 1'b1, 16'd2, 8'd0, 8'd0));
        send(descriptor(8'd1, FC_WRITE_REG, 8'd0, 16'd0, 16'd0, 1'b0, 16'd2, 8'd0, 8'd0));
        send(descriptor(8'd1, 8'd7, 8'd0, 16'd0, 16'd1, 1'b1, 16'd2, 8'd0, 8'd0));

        // random requests, with bursts that never idle
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            send(random_request());
            if (n == RANDOM_ITEMS / 2)
                drain();
            else if (!quiet)
                idle(random_gap());
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/mrv_pkg.sv
rtl/mrv_decode.sv
rtl/modbus_request_validator_top.sv
tb/modbus_request_validator_checker.sv
tb/modbus_request_validator_top_tb.sv
